// ===== src/pcxrle_pkg.sv =====
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants of the PCX run-length plane decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    // Byte values at or above this open a run
    localparam logic [7:0] RUN_MARK = 8'hC0;

    // Width of the result byte offset
    localparam int OFFSET_W = 26;

    // Configuration register indexes (word address bits)
    localparam logic [1:0] REG_LINE_BYTES = 2'd0;
    localparam logic [1:0] REG_LINE_COUNT = 2'd1;
    localparam logic [1:0] REG_PLANES     = 2'd2;

    // Decoded request between front end and sequencer
    typedef struct packed {
        logic [7:0] value;
        logic [5:0] count;
    } t_cmd;

    // Control flags that travel with each result down the back pipeline
    typedef struct packed {
        logic valid;
        logic done;
        logic last;
    } t_flags;

endpackage

// ===== src/pcxrle_front.sv =====
// ----------------------------------------------------------------------------
// pcxrle_front
// Classifies encoded bytes into runs and literals and issues requests.
// ----------------------------------------------------------------------------
module pcxrle_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    output logic                o_push,
    output pcxrle_pkg::t_cmd    o_cmd
);

    logic       r_await_color;
    logic       n_await_color;
    logic [5:0] r_pending_count;
    logic [5:0] n_pending_count;

    // Classify the accepted byte; drop zero-length runs here
    always_comb begin
        n_await_color   = r_await_color;
        n_pending_count = r_pending_count;
        o_push          = 1'b0;
        o_cmd.value     = i_byte;
        o_cmd.count     = 6'd1;
        if (i_accept) begin
            if (r_await_color) begin
                n_await_color = 1'b0;
                o_cmd.count   = r_pending_count;
                o_push        = (r_pending_count != 6'd0);
            end else if (i_byte >= pcxrle_pkg::RUN_MARK) begin
                n_await_color   = 1'b1;
                n_pending_count = i_byte[5:0];
            end else begin
                o_push = 1'b1;
            end
        end
    end

    // Hold the run header state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await_color   <= 1'b0;
            r_pending_count <= 6'd0;
        end else begin
            r_await_color   <= n_await_color;
            r_pending_count <= n_pending_count;
        end
    end

endmodule

// ===== src/pcxrle_queue.sv =====
// ----------------------------------------------------------------------------
// pcxrle_queue
// Two-entry request queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module pcxrle_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pcxrle_pkg::t_cmd    i_cmd,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_full,
    output pcxrle_pkg::t_cmd    o_cmd
);

    pcxrle_pkg::t_cmd r_entry [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_cmd   = r_entry[r_rd_ptr];

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/pcxrle_seq.sv =====
// ----------------------------------------------------------------------------
// pcxrle_seq
// Emits the pixels of each request and walks column, plane and row.
// ----------------------------------------------------------------------------
module pcxrle_seq #(
    parameter int CW = 12,
    parameter int RW = 12,
    parameter int WW = 13,
    parameter int HW = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_q_valid,
    input  pcxrle_pkg::t_cmd    i_q_cmd,
    output logic                o_q_pop,
    input  logic [WW-1:0]       i_eff_w,
    input  logic [HW-1:0]       i_eff_h,
    input  logic [2:0]          i_eff_p,
    output pcxrle_pkg::t_flags  o_flags,
    output logic [7:0]          o_value,
    output logic [CW-1:0]       o_col,
    output logic [RW-1:0]       o_row,
    output logic [1:0]          o_plane,
    output logic [WW-1:0]       o_w,
    output logic [2:0]          o_p
);

    logic          r_busy,      n_busy;
    logic [7:0]    r_value,     n_value;
    logic [5:0]    r_remaining, n_remaining;
    logic [CW-1:0] r_col,       n_col;
    logic [1:0]    r_plane,     n_plane;
    logic [RW-1:0] r_row,       n_row;
    logic          r_finished,  n_finished;

    logic [CW:0]   col_inc;
    logic [2:0]    plane_inc;
    logic [RW:0]   row_inc;
    logic          col_wrap;
    logic          plane_wrap;
    logic          row_last;
    logic          row_end;
    logic          emit;
    logic          last_now;

    pcxrle_pkg::t_flags r_flags;
    logic [7:0]         r_out_value;
    logic [CW-1:0]      r_out_col;
    logic [RW-1:0]      r_out_row;
    logic [1:0]         r_out_plane;
    logic [WW-1:0]      r_out_w;
    logic [2:0]         r_out_p;

    // Position advance and run control
    always_comb begin
        col_inc    = {1'b0, r_col} + {{CW{1'b0}}, 1'b1};
        plane_inc  = {1'b0, r_plane} + 3'd1;
        row_inc    = {1'b0, r_row} + {{RW{1'b0}}, 1'b1};
        col_wrap   = (32'(col_inc) >= 32'(i_eff_w));
        plane_wrap = (plane_inc >= i_eff_p);
        row_last   = (32'(row_inc) >= 32'(i_eff_h));
        row_end    = col_wrap && plane_wrap;
        emit       = r_busy && i_en;
        last_now   = (r_remaining == 6'd1) || row_end;
        o_q_pop    = i_q_valid && i_en && (!r_busy || last_now);

        n_busy      = r_busy;
        n_value     = r_value;
        n_remaining = r_remaining;
        n_col       = r_col;
        n_plane     = r_plane;
        n_row       = r_row;
        n_finished  = r_finished;

        if (emit) begin
            n_remaining = r_remaining - 6'd1;
            n_col       = col_wrap ? '0 : col_inc[CW-1:0];
            if (col_wrap) begin
                n_plane = plane_wrap ? 2'd0 : plane_inc[1:0];
                if (plane_wrap) begin
                    if (row_last) begin
                        n_finished = 1'b1;
                    end else begin
                        n_row = row_inc[RW-1:0];
                    end
                end
            end
            if (last_now) begin
                n_busy = 1'b0;
            end
        end

        // Load the next request; discard it once the image is complete
        if (o_q_pop && !n_finished) begin
            n_busy      = 1'b1;
            n_value     = i_q_cmd.value;
            n_remaining = i_q_cmd.count;
        end
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_remaining <= 6'd0;
            r_col       <= '0;
            r_plane     <= 2'd0;
            r_row       <= '0;
            r_finished  <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_remaining <= n_remaining;
            r_col       <= n_col;
            r_plane     <= n_plane;
            r_row       <= n_row;
            r_finished  <= n_finished;
        end
        r_value <= n_value;
    end

    // Register the emitted pixel for the address stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_en) begin
            r_flags.valid <= emit;
            r_flags.done  <= row_end && row_last;
            r_flags.last  <= last_now;
        end
        if (i_en) begin
            r_out_value <= r_value;
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_plane <= r_plane;
            r_out_w     <= i_eff_w;
            r_out_p     <= i_eff_p;
        end
    end

    assign o_flags = r_flags;
    assign o_value = r_out_value;
    assign o_col   = r_out_col;
    assign o_row   = r_out_row;
    assign o_plane = r_out_plane;
    assign o_w     = r_out_w;
    assign o_p     = r_out_p;

endmodule

// ===== src/pcxrle_addr.sv =====
// ----------------------------------------------------------------------------
// pcxrle_addr
// Two-stage byte offset computation and the output register.
// ----------------------------------------------------------------------------
module pcxrle_addr #(
    parameter int CW = 12,
    parameter int RW = 12,
    parameter int WW = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  pcxrle_pkg::t_flags            i_flags,
    input  logic [7:0]                    i_value,
    input  logic [CW-1:0]                 i_col,
    input  logic [RW-1:0]                 i_row,
    input  logic [1:0]                    i_plane,
    input  logic [WW-1:0]                 i_w,
    input  logic [2:0]                    i_p,
    output pcxrle_pkg::t_flags            o_flags,
    output logic [7:0]                    o_value,
    output logic [pcxrle_pkg::OFFSET_W-1:0] o_offset
);

    localparam int OW = pcxrle_pkg::OFFSET_W;

    pcxrle_pkg::t_flags r_flags2;
    logic [RW+WW-1:0]   r_prod;
    logic [7:0]         r_value2;
    logic [CW-1:0]      r_col2;
    logic [1:0]         r_plane2;
    logic [2:0]         r_p2;

    pcxrle_pkg::t_flags r_flags3;
    logic [7:0]         r_value3;
    logic [OW-1:0]      r_offset3;

    logic [OW-1:0]      pix;
    logic [OW-1:0]      scaled;
    logic [OW-1:0]      offset;

    // Stage two: row times line width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags2 <= '0;
        end else if (i_en) begin
            r_flags2 <= i_flags;
        end
        if (i_en) begin
            r_prod   <= (RW+WW)'(i_row) * (RW+WW)'(i_w);
            r_value2 <= i_value;
            r_col2   <= i_col;
            r_plane2 <= i_plane;
            r_p2     <= i_p;
        end
    end

    // Scale the pixel index by the plane count and place the plane byte
    always_comb begin
        pix = OW'(r_prod) + OW'(r_col2);
        case (r_p2)
            3'd1:    scaled = pix;
            3'd2:    scaled = pix << 1;
            3'd3:    scaled = (pix << 1) + pix;
            default: scaled = pix << 2;
        endcase
        offset = scaled + OW'(r_p2) - OW'(1) - OW'(r_plane2);
    end

    // Stage three: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags3 <= '0;
        end else if (i_en) begin
            r_flags3 <= r_flags2;
        end
        if (i_en) begin
            r_value3  <= r_value2;
            r_offset3 <= offset;
        end
    end

    assign o_flags  = r_flags3;
    assign o_value  = r_value3;
    assign o_offset = r_offset3;

endmodule

// ===== src/pcx_rle_plane_decoder.sv =====
// ----------------------------------------------------------------------------
// pcx_rle_plane_decoder
// PCX run-length decoder that writes each plane byte with its interleaved
// memory offset.
// ----------------------------------------------------------------------------
// Path: a literal or run color byte passes the queue, the sequencer, the multiply
//   stage and the output register before its first result appears.
// Throughput: the sequencer emits one pixel per cycle while the back pipeline is
//   not stalled; a run header issues no request to it.
// Reset (synchronous, active low) clears position, queue, pipeline and
//   registers (line_bytes, line_count, planes back to 1).
// ----------------------------------------------------------------------------
module pcx_rle_plane_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Encoded byte stream
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_encoded_byte,
    // Decoded pixel stream
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_pixel_value,
    output logic [pcxrle_pkg::OFFSET_W-1:0] o_byte_offset,
    output logic                            o_image_done,
    output logic                            o_last,
    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [12:0] r_line_bytes;
    logic [12:0] r_line_count;
    logic [2:0]  r_planes;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [2:0]    eff_p;

    logic             en;
    logic             in_accept;
    logic             push;
    pcxrle_pkg::t_cmd front_cmd;
    logic             q_valid;
    logic             q_full;
    logic             q_pop;
    pcxrle_pkg::t_cmd q_cmd;

    pcxrle_pkg::t_flags s1_flags;
    logic [7:0]         s1_value;
    logic [CW-1:0]      s1_col;
    logic [RW-1:0]      s1_row;
    logic [1:0]         s1_plane;
    logic [WW-1:0]      s1_w;
    logic [2:0]         s1_p;
    pcxrle_pkg::t_flags out_flags;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes <= 13'd1;
            r_line_count <= 13'd1;
            r_planes     <= 3'd1;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                pcxrle_pkg::REG_LINE_BYTES: r_line_bytes <= pwdata[12:0];
                pcxrle_pkg::REG_LINE_COUNT: r_line_count <= pwdata[12:0];
                pcxrle_pkg::REG_PLANES:     r_planes     <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            pcxrle_pkg::REG_LINE_BYTES: prdata = {19'd0, r_line_bytes};
            pcxrle_pkg::REG_LINE_COUNT: prdata = {19'd0, r_line_count};
            pcxrle_pkg::REG_PLANES:     prdata = {29'd0, r_planes};
            default:                    prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // Clamp registers to their working ranges
    always_comb begin
        if (r_line_bytes == 13'd0) begin
            eff_w = WW'(1);
        end else if (32'(r_line_bytes) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_line_bytes);
        end
        if (r_line_count == 13'd0) begin
            eff_h = HW'(1);
        end else if (32'(r_line_count) > 32'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_line_count);
        end
        if (r_planes == 3'd0) begin
            eff_p = 3'd1;
        end else if (r_planes > 3'd4) begin
            eff_p = 3'd4;
        end else begin
            eff_p = r_planes;
        end
    end

    // Back pipeline moves unless a result is held by the consumer
    assign en        = !(o_valid && i_stall);
    assign o_stall   = q_full;
    assign in_accept = i_valid && !o_stall;

    pcxrle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_encoded_byte),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    pcxrle_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_full   (q_full),
        .o_cmd    (q_cmd)
    );

    pcxrle_seq #(
        .CW (CW),
        .RW (RW),
        .WW (WW),
        .HW (HW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .i_eff_w   (eff_w),
        .i_eff_h   (eff_h),
        .i_eff_p   (eff_p),
        .o_flags   (s1_flags),
        .o_value   (s1_value),
        .o_col     (s1_col),
        .o_row     (s1_row),
        .o_plane   (s1_plane),
        .o_w       (s1_w),
        .o_p       (s1_p)
    );

    pcxrle_addr #(
        .CW (CW),
        .RW (RW),
        .WW (WW)
    ) u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_flags  (s1_flags),
        .i_value  (s1_value),
        .i_col    (s1_col),
        .i_row    (s1_row),
        .i_plane  (s1_plane),
        .i_w      (s1_w),
        .i_p      (s1_p),
        .o_flags  (out_flags),
        .o_value  (o_pixel_value),
        .o_offset (o_byte_offset)
    );

    assign o_valid      = out_flags.valid;
    assign o_image_done = out_flags.done;
    assign o_last       = out_flags.last;

endmodule

// ===== src/pcxrle_checker.sv =====
// ----------------------------------------------------------------------------
// pcxrle_checker
// Port-level checks of the PCX run-length plane decoder.
// ----------------------------------------------------------------------------
module pcxrle_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [7:0]  o_pixel_value,
    input  logic [25:0] o_byte_offset,
    input  logic        o_image_done,
    input  logic        o_last,
    input  logic        pready
);

    // Hold a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_value)
            && $stable(o_byte_offset) && $stable(o_last))
        else $error("stalled result changed");

    // The result that completes the image closes its request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_image_done |-> o_last)
        else $error("image_done without last");

    // Nothing follows the final result of the image
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_image_done |=> !o_valid)
        else $error("result after image completion");

    // Pixels of one run leave without gaps
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("gap inside a run");

    // Register port never waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind pcx_rle_plane_decoder pcxrle_checker u_pcxrle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_pixel_value (o_pixel_value),
    .o_byte_offset (o_byte_offset),
    .o_image_done  (o_image_done),
    .o_last        (o_last),
    .pready        (pready)
);
